[src/lsm_pkg.sv]
// Shared types and constants for the learning MAC table.
// Item structs for both channels and the token that walks the cell chain.
// No dependencies.
package lsm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int PORTS       = 16;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 4;
  localparam int MASK_W  = 16;
  localparam int PCNT_W  = 5;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // register index within the configuration space
  localparam logic REG_PORT_COUNT = 1'b0;

  localparam logic [PCNT_W-1:0] PORT_COUNT_RESET = PCNT_W'(16);

  typedef struct packed {
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] src_port;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic              dest_hit;
    logic              learned_new;
    logic              table_full;
  } out_item_t;

  // header in flight through the chain, with what it has found so far
  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] src_port;
    logic              src_found;
    logic              learned;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } token_t;

endpackage

[src/lsm_cell.sv]
// One table entry of the learning MAC table plus one stage of the search chain.
// Depends on lsm_pkg (token_t, widths).
module lsm_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           occupied,
  input  lsm_pkg::token_t tok_in,
  output lsm_pkg::token_t tok_out,
  output logic           learn
);
  import lsm_pkg::*;

  logic [MAC_W-1:0]  entry_mac;
  logic [PORT_W-1:0] entry_port;
  logic              match_src;
  logic              match_dst;
  token_t            tok_next;
  token_t            tok_q;

  assign match_src = occupied && (entry_mac == tok_in.src_mac);
  assign match_dst = occupied && (entry_mac == tok_in.dst_mac);

  // first free entry reached with an unknown source: claim it
  assign learn = tok_in.valid && !occupied && !tok_in.src_found && !tok_in.learned;

  always_comb begin
    tok_next           = tok_in;
    tok_next.src_found = tok_in.src_found || match_src;
    tok_next.learned   = tok_in.learned || learn;
    if (match_dst) begin
      tok_next.dst_hit  = 1'b1;
      tok_next.dst_port = entry_port;
    end else if (learn && (tok_in.dst_mac == tok_in.src_mac)) begin
      // frame addressed to itself: hits the entry it just made
      tok_next.dst_hit  = 1'b1;
      tok_next.dst_port = tok_in.src_port;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && learn) begin
      entry_mac  <= tok_in.src_mac;
      entry_port <= tok_in.src_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else if (advance) begin
      tok_q <= tok_next;
    end
  end

  assign tok_out = tok_q;

endmodule

[src/learning_switch_mac_table.sv]
// Top level of the learning MAC table: cell chain, fill count, flood logic
// and the APB register port. Depends on lsm_pkg and lsm_cell.
//
// Each frame header enters a chain of TABLE_DEPTH cells, each cell holding one
// learned entry, and moves one cell per cycle. On its way it matches the
// source and destination MAC against every entry; an unknown source is written
// into the first free cell it passes. A new header is taken every cycle, and
// its forwarding decision leaves the end of the chain, in order.
// A header that follows a learning header directly still sees the new entry,
// because it reaches that cell only after the write. Latency is set by the
// chain length; throughput is one item per cycle. A stall on the output
// freezes the whole chain. The table holds entries until reset, with no aging
// and no overwrite; port_count (register 0, reset 16) limits flooding only.
module learning_switch_mac_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  lsm_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output lsm_pkg::out_item_t       out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [lsm_pkg::ADDR_W-1:0] paddr,
  input  logic [lsm_pkg::DATA_W-1:0] pwdata,
  output logic [lsm_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);
  import lsm_pkg::*;

  token_t            chain [TABLE_DEPTH+1];
  token_t            head;
  logic [TABLE_DEPTH-1:0] learn_vec;
  logic [TABLE_DEPTH-1:0] occupied;
  logic [CNT_W-1:0]  entry_count;
  logic [PCNT_W-1:0] port_count;
  logic              advance;
  logic              cfg_write;
  logic              reg_sel;
  token_t            tail;
  logic [MASK_W-1:0] flood_mask;

  // whole chain moves unless a finished item is held at the output
  assign advance  = !(chain[TABLE_DEPTH].valid && out_stall);
  assign in_stall = !advance;

  always_comb begin
    head          = '0;
    head.valid    = in_valid;
    head.src_mac  = in_data.src_mac;
    head.dst_mac  = in_data.dst_mac;
    head.src_port = in_data.src_port;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    // entries fill in order, so the count says which cells hold data
    assign occupied[i] = CNT_W'(i) < entry_count;

    lsm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .occupied (occupied[i]),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1]),
      .learn    (learn_vec[i])
    );
  end

  // only the cell at the fill point can learn, so at most one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (advance && (|learn_vec)) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // APB register port
  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_W-1];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count <= PORT_COUNT_RESET;
    end else if (cfg_write && (reg_sel == REG_PORT_COUNT)) begin
      port_count <= pwdata[PCNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_PORT_COUNT) begin
      prdata = DATA_W'(port_count);
    end
  end

  // output decision from the last chain stage
  assign tail = chain[TABLE_DEPTH];

  always_comb begin
    for (int p = 0; p < MASK_W; p++) begin
      // values of port_count above PORTS clip here as the loop ends at PORTS
      flood_mask[p] = (p < PORTS) && (32'(port_count) > p) &&
                      (PORT_W'(p) != tail.src_port);
    end
  end

  always_comb begin
    out_data.dest_hit    = tail.dst_hit;
    out_data.learned_new = tail.learned;
    out_data.table_full  = !tail.src_found && !tail.learned;
    if (tail.dst_hit) begin
      out_data.egress_mask = MASK_W'(1) << tail.dst_port;
    end else begin
      out_data.egress_mask = flood_mask;
    end
  end

  assign out_valid = tail.valid;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_one_learn: assert property (@(posedge clk) disable iff (rst)
    $onehot0(learn_vec))
    else $error("more than one cell learning at once");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (advance && (|learn_vec)) |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("entry count did not follow a learn");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.table_full) |-> entry_count == CNT_W'(TABLE_DEPTH))
    else $error("table full reported with free entries");

  a_learn_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.learned_new && out_data.table_full))
    else $error("learned and full on the same item");
`endif

endmodule

[verif/tb_top.sv]
// Testbench for learning_switch_mac_table: directed and random frame headers,
// checked against an in-bench copy of the forwarding table.
// Depends on lsm_pkg and the learning_switch_mac_table RTL.
`timescale 1ns / 100ps

module tb_top;
  import lsm_pkg::*;

  // register map: port_count at index 0, index 1 is unused and must ignore writes
  localparam int REG_SPARE  = 1;
  localparam int DRAIN_WAIT = TABLE_DEPTH + 16;   // chain length plus margin

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  learning_switch_mac_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the forwarding table and the flooding register
  // --------------------------------------------------------------------------
  logic [MAC_W-1:0]   fdb_mac  [TABLE_DEPTH];
  logic [PORT_W-1:0]  fdb_port [TABLE_DEPTH];
  int                 fdb_count;
  logic [PCNT_W-1:0]  flood_ports;

  out_item_t          expected_decisions[$];   // forwarding decisions still owed
  logic [MAC_W-1:0]   heard_macs[$];           // every source seen, learned or not
  int                 mismatches;
  bit                 steady_traffic;          // suppresses idling on both sides

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run-time guard, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Learns the source if new and room remains, then forwards on the destination.
  // Learning comes first, so a frame addressed to itself hits its own new entry.
  function automatic out_item_t learn_and_forward(input in_item_t hdr);
    out_item_t decision;
    bit        src_known;
    int        flood_limit;
    decision  = '0;
    src_known = 1'b0;
    for (int i = 0; i < fdb_count; i++)
      if (fdb_mac[i] == hdr.src_mac) src_known = 1'b1;
    if (!src_known) begin
      if (fdb_count < TABLE_DEPTH) begin
        fdb_mac[fdb_count]  = hdr.src_mac;
        fdb_port[fdb_count] = hdr.src_port;
        fdb_count++;
        decision.learned_new = 1'b1;
      end else begin
        decision.table_full = 1'b1;
      end
    end
    for (int i = 0; i < fdb_count; i++) begin
      if (fdb_mac[i] == hdr.dst_mac) begin
        // one-hot on the stored port, even if it is the ingress port or
        // lies beyond port_count
        decision.dest_hit    = 1'b1;
        decision.egress_mask = MASK_W'(1) << fdb_port[i];
      end
    end
    if (!decision.dest_hit) begin
      // flood: port_count above PORTS saturates, zero floods nowhere
      flood_limit = (int'(flood_ports) > PORTS) ? PORTS : int'(flood_ports);
      for (int p = 0; p < flood_limit; p++)
        if (p != int'(hdr.src_port)) decision.egress_mask[p] = 1'b1;
    end
    return decision;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stall, and each accepted item against the oldest
  // outstanding decision
  // --------------------------------------------------------------------------
  always @(negedge clk)
    out_stall <= !steady_traffic && ($urandom_range(99) < 6);

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_decisions.size() == 0) begin
        report_mismatch("unexpected result", DATA_W'(out_data), '0);
      end else begin
        want = expected_decisions.pop_front();
        if (out_data.egress_mask !== want.egress_mask)
          report_mismatch("egress_mask", DATA_W'(out_data.egress_mask),
                          DATA_W'(want.egress_mask));
        if (out_data.dest_hit !== want.dest_hit)
          report_mismatch("dest_hit", DATA_W'(out_data.dest_hit), DATA_W'(want.dest_hit));
        if (out_data.learned_new !== want.learned_new)
          report_mismatch("learned_new", DATA_W'(out_data.learned_new),
                          DATA_W'(want.learned_new));
        if (out_data.table_full !== want.table_full)
          report_mismatch("table_full", DATA_W'(out_data.table_full),
                          DATA_W'(want.table_full));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Called and returns at a falling edge; valid is left high so
  // back-to-back items never drop it within a time step.
  // --------------------------------------------------------------------------
  task automatic send_frame(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                            input logic [PORT_W-1:0] port);
    in_item_t hdr;
    hdr.src_mac  = src;
    hdr.dst_mac  = dst;
    hdr.src_port = port;
    while (!steady_traffic && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= hdr;
    do @(posedge clk); while (in_stall);
    expected_decisions.push_back(learn_and_forward(hdr));
    heard_macs.push_back(src);
    @(negedge clk);
  endtask

  // Stop sending and wait for every owed decision; the chain is then empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_decisions.size() != 0) @(negedge clk);
  endtask

  // APB: setup phase, access phase, then an idle phase with psel low so the next
  // transfer never drives psel twice in one step.
  task automatic apb_write(input int idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_read(input int idx, output logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * idx);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_port_count();
    logic [DATA_W-1:0] readback;
    apb_read(int'(REG_PORT_COUNT), readback);
    if (readback !== DATA_W'(flood_ports))
      report_mismatch("port_count readback", readback, DATA_W'(flood_ports));
  endtask

  task automatic set_port_count(input logic [PCNT_W-1:0] value);
    drain_results();
    apb_write(int'(REG_PORT_COUNT), DATA_W'(value));
    flood_ports = value;
    check_port_count();
  endtask

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(11))
      0:       return '1;
      1:       return '0;
      2:       return MAC_W'(1) << $urandom_range(MAC_W - 1);
      default: return raw[MAC_W-1:0];
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, learning, known sources, self-addressed frames, hits on
  // the ingress port, plain misses. Table starts empty, port_count at reset.
  task automatic test_learn_and_lookup();
    check_port_count();                                    // reset value 16
    send_frame('0, '0, 4'd0);                              // learn then hit itself
    send_frame('1, 48'h0123_4567_89ab, 4'd15);             // learn, miss, flood all but 15
    send_frame('0, '1, 4'd7);                              // known source, hit port 15
    send_frame(48'haaaa_aaaa_aaaa, 48'haaaa_aaaa_aaaa, 4'd10);  // hit on ingress port
    send_frame(48'h5555_5555_5555, '0, 4'd3);
    send_frame('1, 48'h5555_5555_5555, 4'd15);             // known source, hit port 3
    send_frame(48'h0000_0000_0001, 48'h8000_0000_0000, 4'd0);   // miss from port 0
    send_frame(48'h8000_0000_0000, 48'h0000_0000_0001, 4'd6);   // learn, hit earlier entry
    send_frame(48'h0123_4567_89ab, 48'h8000_0000_0000, 4'd9);   // dest learned one frame back
    send_frame(48'h0000_0000_0001, 48'h0123_4567_89ab, 4'd2);   // known source, ingress differs
  endtask

  // Flood limits: unused index ignored, zero, one, saturating values, and
  // hits on ports beyond port_count.
  task automatic test_flood_limits();
    drain_results();
    apb_write(REG_SPARE, '0);
    check_port_count();                                    // still 16
    send_frame(48'h0123_4567_89ab, 48'hdead_beef_0000, 4'd4);
    set_port_count(5'd0);
    send_frame(48'h0123_4567_89ab, 48'hdead_beef_0001, 4'd4);   // miss floods nowhere
    send_frame(48'h0123_4567_89ab, 48'haaaa_aaaa_aaaa, 4'd4);   // hit still forwards
    set_port_count(5'd1);
    send_frame('0, 48'hdead_beef_0002, 4'd0);              // only port is ingress
    send_frame('0, 48'hdead_beef_0003, 4'd3);              // floods to port 0 alone
    send_frame('0, 48'haaaa_aaaa_aaaa, 4'd0);              // hit beyond port_count
    set_port_count(5'd31);
    send_frame('1, 48'hdead_beef_0004, 4'd2);              // saturates at PORTS
    set_port_count(5'd17);
    send_frame('1, 48'hdead_beef_0005, 4'd15);
    set_port_count(5'd16);
    send_frame('1, 48'hdead_beef_0006, 4'd8);
  endtask

  // Random headers over several port_count settings. About a third of sources
  // are new, so the table fills early and most of the run sees a full table;
  // destinations mostly hit learned entries.
  task automatic test_random_traffic();
    int               settings[8];
    int               pick;
    logic [MAC_W-1:0] src;
    logic [MAC_W-1:0] dst;
    settings = '{16, 4, 0, 31, 1, 9, 16, -1};
    for (int phase = 0; phase < 8; phase++) begin
      set_port_count(settings[phase] < 0 ? PCNT_W'($urandom_range(31))
                                         : PCNT_W'(settings[phase]));
      steady_traffic = (phase == 5);                       // one long stretch with no idling
      repeat (190) begin
        pick = $urandom_range(99);
        if (pick < 35 || fdb_count == 0)
          src = random_mac();
        else if (pick < 85)
          src = fdb_mac[$urandom_range(fdb_count - 1)];
        else
          src = heard_macs[$urandom_range(heard_macs.size() - 1)];
        pick = $urandom_range(99);
        if (pick < 10)
          dst = src;
        else if (pick < 60 && fdb_count != 0)
          dst = fdb_mac[$urandom_range(fdb_count - 1)];
        else if (pick < 75)
          dst = heard_macs[$urandom_range(heard_macs.size() - 1)];
        else
          dst = random_mac();
        send_frame(src, dst, PORT_W'($urandom_range(15)));
      end
      steady_traffic = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fdb_count      = 0;
    flood_ports    = PORT_COUNT_RESET;
    mismatches     = 0;
    steady_traffic = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_learn_and_lookup();
    test_flood_limits();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_WAIT) @(negedge clk);                    // catch any stray result
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
